FILE: hdl/shape_fill_lcd_write_generator_defines.svh
// assertion macros for the shape fill lcd write generator checker
// expects signals named clk and rst in the scope of use
`ifndef SHAPE_FILL_LCD_WRITE_GENERATOR_DEFINES_SVH
`define SHAPE_FILL_LCD_WRITE_GENERATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define SFL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfl check failed");

// next-cycle implication, off during reset
`define SFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfl check failed");

// next-cycle implication, always active
`define SFL_ASSERT_ALWAYS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sfl check failed");

`endif

FILE: hdl/sfl_pkg.sv
// shared constants, codes and types of the shape fill lcd write generator
// no dependencies
`default_nettype none

package sfl_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;

  localparam int PX_W        = 8;
  localparam int PY_W        = 9;
  localparam int COORD_W     = 11;
  localparam int COLOUR_W    = 16;
  localparam int VALUE_W     = 16;
  localparam int KIND_W      = 2;
  localparam int SEL_W       = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int SCREEN_CMP_W = 11;
  localparam int DIFF_W      = 12;
  localparam int PROD_W      = 24;
  localparam int EDGE_W      = 25;
  localparam int POS_W       = 3;
  localparam logic [POS_W-1:0] PRE_LEN = 3'd3;

  localparam logic [KIND_W-1:0] ACC_REG_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] ACC_INDEX     = 2'd1;
  localparam logic [KIND_W-1:0] ACC_DATA      = 2'd2;
  localparam logic [KIND_W-1:0] ACC_NONE      = 2'd3;

  localparam logic [SEL_W-1:0] SEL_CURSOR_X = 2'd0;
  localparam logic [SEL_W-1:0] SEL_CURSOR_Y = 2'd1;
  localparam logic [SEL_W-1:0] SEL_DATA     = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SHAPE_MODE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILL_COLOUR = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_A_X   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_A_Y   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_B_X   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_B_Y   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_C_X   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_C_Y   = 3'd7;

  typedef struct packed {
    logic                      shape_mode;
    logic [COLOUR_W-1:0]       fill_colour;
    logic signed [COORD_W-1:0] point_a_x;
    logic signed [COORD_W-1:0] point_a_y;
    logic signed [COORD_W-1:0] point_b_x;
    logic signed [COORD_W-1:0] point_b_y;
    logic signed [COORD_W-1:0] point_c_x;
    logic signed [COORD_W-1:0] point_c_y;
  } cfg_t;

  typedef struct packed {
    logic [PX_W-1:0] pixel_x;
    logic [PY_W-1:0] pixel_y;
    logic            frame_start;
  } pix_t;

  function automatic logic signed [DIFF_W-1:0] sext(input logic signed [COORD_W-1:0] v);
    return DIFF_W'(v);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sfl_if.sv
// valid/ready channel interfaces: pixel input and lcd write output
// uses sfl_pkg for field widths
`default_nettype none

interface sfl_pixel_if;
  logic                     valid;
  logic                     ready;
  logic [sfl_pkg::PX_W-1:0] pixel_x;
  logic [sfl_pkg::PY_W-1:0] pixel_y;
  logic                     frame_start;

  modport source (output valid, output pixel_x, output pixel_y, output frame_start,
                  input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input frame_start,
                output ready);
endinterface

interface sfl_write_if;
  logic                        valid;
  logic                        ready;
  logic [sfl_pkg::KIND_W-1:0]  access_kind;
  logic [sfl_pkg::SEL_W-1:0]   reg_select;
  logic [sfl_pkg::VALUE_W-1:0] value;
  logic                        last;

  modport source (output valid, output access_kind, output reg_select, output value,
                  output last, input ready);
  modport sink (input valid, input access_kind, input reg_select, input value,
                input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/sfl_inside.sv
// two-stage inside test: pixel register, product register, then sign and compare
// uses sfl_pkg
`default_nettype none

module sfl_inside (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire sfl_pkg::cfg_t  cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sfl_pkg::pix_t  in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sfl_pkg::pix_t       out_item,
  output logic                out_inside
);

  logic          s0_valid;
  sfl_pkg::pix_t s0_item;
  logic          s1_valid;
  logic          s1_ready;
  sfl_pkg::pix_t s1_item;
  logic          s1_onscreen;

  logic signed [sfl_pkg::PROD_W-1:0] s1_pa [3];
  logic signed [sfl_pkg::PROD_W-1:0] s1_pb [3];
  logic signed [sfl_pkg::PROD_W-1:0] s1_dx2;
  logic signed [sfl_pkg::PROD_W-1:0] s1_dy2;
  logic signed [sfl_pkg::PROD_W-1:0] s1_r2;

  logic signed [sfl_pkg::DIFF_W-1:0] px_s;
  logic signed [sfl_pkg::DIFF_W-1:0] py_s;
  logic signed [sfl_pkg::DIFF_W-1:0] vx [3];
  logic signed [sfl_pkg::DIFF_W-1:0] vy [3];
  logic signed [sfl_pkg::PROD_W-1:0] pa [3];
  logic signed [sfl_pkg::PROD_W-1:0] pb [3];
  logic signed [sfl_pkg::DIFF_W-1:0] dx;
  logic signed [sfl_pkg::DIFF_W-1:0] dy;
  logic signed [sfl_pkg::DIFF_W-1:0] rad;
  logic                              onscreen;

  logic signed [sfl_pkg::EDGE_W-1:0] d [3];
  logic signed [sfl_pkg::EDGE_W-1:0] dist2;
  logic                              any_neg;
  logic                              any_pos;
  logic                              tri_in;
  logic                              circ_in;

  assign s1_ready = !s1_valid || out_ready;
  assign in_ready = !s0_valid || s1_ready;

  // stage 0: differences and products
  always_comb begin
    int k;
    int b;
    px_s  = $signed(sfl_pkg::DIFF_W'(s0_item.pixel_x));
    py_s  = $signed(sfl_pkg::DIFF_W'(s0_item.pixel_y));
    vx[0] = sfl_pkg::sext(cfg.point_a_x);
    vy[0] = sfl_pkg::sext(cfg.point_a_y);
    vx[1] = sfl_pkg::sext(cfg.point_b_x);
    vy[1] = sfl_pkg::sext(cfg.point_b_y);
    vx[2] = sfl_pkg::sext(cfg.point_c_x);
    vy[2] = sfl_pkg::sext(cfg.point_c_y);
    for (k = 0; k < 3; k++) begin
      b = (k == 2) ? 0 : k + 1;
      pa[k] = sfl_pkg::PROD_W'(px_s - vx[b]) * sfl_pkg::PROD_W'(vy[k] - vy[b]);
      pb[k] = sfl_pkg::PROD_W'(vx[k] - vx[b]) * sfl_pkg::PROD_W'(py_s - vy[b]);
    end
    dx  = px_s - vx[0];
    dy  = py_s - vy[0];
    rad = vx[1];
    onscreen = (sfl_pkg::SCREEN_CMP_W'(s0_item.pixel_x) <
                sfl_pkg::SCREEN_CMP_W'(sfl_pkg::SCREEN_WIDTH)) &&
               (sfl_pkg::SCREEN_CMP_W'(s0_item.pixel_y) <
                sfl_pkg::SCREEN_CMP_W'(sfl_pkg::SCREEN_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s0_valid <= in_valid;
      end
      if (s1_ready) begin
        s1_valid <= s0_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_item <= in_item;
    end
    if (s1_ready) begin
      s1_item     <= s0_item;
      s1_onscreen <= onscreen;
      s1_pa       <= pa;
      s1_pb       <= pb;
      s1_dx2      <= sfl_pkg::PROD_W'(dx) * sfl_pkg::PROD_W'(dx);
      s1_dy2      <= sfl_pkg::PROD_W'(dy) * sfl_pkg::PROD_W'(dy);
      s1_r2       <= sfl_pkg::PROD_W'(rad) * sfl_pkg::PROD_W'(rad);
    end
  end

  // stage 1: edge signs and radius compare
  always_comb begin
    int k;
    any_neg = 1'b0;
    any_pos = 1'b0;
    for (k = 0; k < 3; k++) begin
      d[k]    = sfl_pkg::EDGE_W'(s1_pa[k]) - sfl_pkg::EDGE_W'(s1_pb[k]);
      any_neg = any_neg || d[k][sfl_pkg::EDGE_W-1];
      any_pos = any_pos || (!d[k][sfl_pkg::EDGE_W-1] && (d[k] != '0));
    end
    tri_in  = !(any_neg && any_pos);
    dist2   = sfl_pkg::EDGE_W'(s1_dx2) + sfl_pkg::EDGE_W'(s1_dy2);
    circ_in = dist2 < sfl_pkg::EDGE_W'(s1_r2);
  end

  assign out_valid  = s1_valid;
  assign out_item   = s1_item;
  assign out_inside = s1_onscreen && (cfg.shape_mode ? circ_in : tri_in);

endmodule

`default_nettype wire

FILE: hdl/shape_fill_lcd_write_generator.sv
// shape fill lcd write generator: pixel scan in, lcd bus accesses out
// uses sfl_pkg, sfl_if and sfl_inside
//
// pixel channel: one screen coordinate per transfer, raster order, frame_start
// on the first pixel of a frame. write channel: lcd accesses, one per transfer,
// last set on the final access caused by a pixel.
// configuration: cfg_write with cfg_index and cfg_data writes one register,
// to be used only while the block is idle.
// path: the first access of a pixel passes the pixel and product registers
// of sfl_inside, the current-pixel register and the output register.
// throughput: a pixel causes one access inside a run or outside the shape,
// three for an inside pixel after a break, plus three for the frame-start
// preamble; pixels following one another with one access each go at one
// per cycle while the receiver is ready, set by the single output register.
// reset clears the pipeline, the configuration registers and sets the
// cursor run flag. when the receiver stalls the output register holds its
// access and the pipeline backs up to the pixel channel's ready.
`default_nettype none

module shape_fill_lcd_write_generator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  sfl_pixel_if.sink                                pixel,
  sfl_write_if.source                              write,
  input  wire logic                                cfg_write,
  input  wire logic [sfl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [sfl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  sfl_pkg::cfg_t cfg;
  sfl_pkg::pix_t in_item;
  sfl_pkg::pix_t tst_item;
  logic          tst_valid;
  logic          tst_inside;

  logic                        cursor_in_run;
  logic                        cur_valid;
  sfl_pkg::pix_t               cur_item;
  logic                        cur_inside;
  logic                        cur_run;
  logic [sfl_pkg::POS_W-1:0]   pos;

  logic                        out_valid;
  logic [sfl_pkg::KIND_W-1:0]  out_kind;
  logic [sfl_pkg::SEL_W-1:0]   out_sel;
  logic [sfl_pkg::VALUE_W-1:0] out_value;
  logic                        out_last;

  logic                        emit;
  logic                        cur_take;
  logic [sfl_pkg::POS_W-1:0]   pre_len;
  logic [sfl_pkg::POS_W-1:0]   j;
  logic                        in_pre;
  logic                        split;
  logic [sfl_pkg::KIND_W-1:0]  res_kind;
  logic [sfl_pkg::SEL_W-1:0]   res_sel;
  logic [sfl_pkg::VALUE_W-1:0] res_value;
  logic                        res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sfl_pkg::CFG_SHAPE_MODE:  cfg.shape_mode  <= cfg_data[0];
        sfl_pkg::CFG_FILL_COLOUR: cfg.fill_colour <= cfg_data[sfl_pkg::COLOUR_W-1:0];
        sfl_pkg::CFG_POINT_A_X:   cfg.point_a_x   <= cfg_data[sfl_pkg::COORD_W-1:0];
        sfl_pkg::CFG_POINT_A_Y:   cfg.point_a_y   <= cfg_data[sfl_pkg::COORD_W-1:0];
        sfl_pkg::CFG_POINT_B_X:   cfg.point_b_x   <= cfg_data[sfl_pkg::COORD_W-1:0];
        sfl_pkg::CFG_POINT_B_Y:   cfg.point_b_y   <= cfg_data[sfl_pkg::COORD_W-1:0];
        sfl_pkg::CFG_POINT_C_X:   cfg.point_c_x   <= cfg_data[sfl_pkg::COORD_W-1:0];
        sfl_pkg::CFG_POINT_C_Y:   cfg.point_c_y   <= cfg_data[sfl_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.pixel_x     = pixel.pixel_x;
  assign in_item.pixel_y     = pixel.pixel_y;
  assign in_item.frame_start = pixel.frame_start;

  sfl_inside u_inside (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (pixel.valid),
    .in_ready   (pixel.ready),
    .in_item    (in_item),
    .out_valid  (tst_valid),
    .out_ready  (cur_take),
    .out_item   (tst_item),
    .out_inside (tst_inside)
  );

  // access sequence of the current pixel
  always_comb begin
    pre_len   = cur_item.frame_start ? sfl_pkg::PRE_LEN : '0;
    in_pre    = cur_item.frame_start && (pos < sfl_pkg::PRE_LEN);
    j         = pos - pre_len;
    split     = cur_inside && !cur_run;
    res_kind  = sfl_pkg::ACC_NONE;
    res_sel   = sfl_pkg::SEL_CURSOR_X;
    res_value = '0;
    res_last  = 1'b0;
    if (in_pre) begin
      case (pos)
        3'd0: begin
          res_kind = sfl_pkg::ACC_REG_WRITE;
          res_sel  = sfl_pkg::SEL_CURSOR_X;
        end
        3'd1: begin
          res_kind = sfl_pkg::ACC_REG_WRITE;
          res_sel  = sfl_pkg::SEL_CURSOR_Y;
        end
        default: begin
          res_kind = sfl_pkg::ACC_INDEX;
          res_sel  = sfl_pkg::SEL_DATA;
        end
      endcase
    end else if (!cur_inside) begin
      res_last = 1'b1;
    end else if (!split) begin
      res_kind  = sfl_pkg::ACC_DATA;
      res_sel   = sfl_pkg::SEL_DATA;
      res_value = cfg.fill_colour;
      res_last  = 1'b1;
    end else begin
      res_kind = sfl_pkg::ACC_REG_WRITE;
      case (j)
        3'd0: begin
          res_sel   = sfl_pkg::SEL_CURSOR_X;
          res_value = sfl_pkg::VALUE_W'(cur_item.pixel_x);
        end
        3'd1: begin
          res_sel   = sfl_pkg::SEL_CURSOR_Y;
          res_value = sfl_pkg::VALUE_W'(cur_item.pixel_y);
        end
        default: begin
          res_sel   = sfl_pkg::SEL_DATA;
          res_value = cfg.fill_colour;
          res_last  = 1'b1;
        end
      endcase
    end
  end

  assign emit     = cur_valid && (!out_valid || write.ready);
  assign cur_take = !cur_valid || (emit && res_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_in_run <= 1'b1;
      cur_valid     <= 1'b0;
      pos           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cur_take) begin
        cur_valid <= tst_valid;
        if (tst_valid) begin
          cursor_in_run <= tst_inside;
        end
      end
      if (emit) begin
        pos <= res_last ? '0 : pos + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (write.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cur_take && tst_valid) begin
      cur_item   <= tst_item;
      cur_inside <= tst_inside;
      cur_run    <= tst_item.frame_start || cursor_in_run;
    end
    if (emit) begin
      out_kind  <= res_kind;
      out_sel   <= res_sel;
      out_value <= res_value;
      out_last  <= res_last;
    end
  end

  assign write.valid       = out_valid;
  assign write.access_kind = out_kind;
  assign write.reg_select  = out_sel;
  assign write.value       = out_value;
  assign write.last        = out_last;

endmodule

`default_nettype wire

FILE: hdl/sfl_checker.sv
// port-level checks of the write channel, bound to the top level
// uses sfl_pkg and shape_fill_lcd_write_generator_defines.svh
`default_nettype none
`include "shape_fill_lcd_write_generator_defines.svh"

module sfl_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [sfl_pkg::KIND_W-1:0]  access_kind,
  input wire logic [sfl_pkg::SEL_W-1:0]   reg_select,
  input wire logic [sfl_pkg::VALUE_W-1:0] value,
  input wire logic                        last
);

  `SFL_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(access_kind) && $stable(reg_select) && $stable(value) && $stable(last))
  `SFL_ASSERT_ALWAYS_NEXT(a_reset_idle, rst, !out_valid)
  `SFL_ASSERT_NOW(a_index_select, out_valid && access_kind == sfl_pkg::ACC_INDEX, reg_select == sfl_pkg::SEL_DATA && !last && value == '0)
  `SFL_ASSERT_NOW(a_noop_last, out_valid && access_kind == sfl_pkg::ACC_NONE, last && reg_select == sfl_pkg::SEL_CURSOR_X && value == '0)

endmodule

bind shape_fill_lcd_write_generator sfl_checker u_sfl_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (write.valid),
  .out_ready   (write.ready),
  .access_kind (write.access_kind),
  .reg_select  (write.reg_select),
  .value       (write.value),
  .last        (write.last)
);

`default_nettype wire
